### src/huffman_code_builder_defines.svh
// Assertion macros for the code builder.
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH
`ifndef SYNTH
`define HCB_CHECK(name, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("code builder check failed");
`define HCB_CHECK_IMP(name, cond, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("code builder check failed");
`else
`define HCB_CHECK(name, expr)
`define HCB_CHECK_IMP(name, cond, expr)
`endif
`endif

### src/hcb_pkg.sv
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF   = 64;
    localparam int MAX_CODE_BITS_DEF = 63;
    localparam int SYM_W             = 8;
    localparam int FREQ_W            = 32;
    localparam int WEIGHT_W          = 38;
    localparam int CODE_W            = 63;
    localparam int LEN_W             = 6;
    localparam int DEPTH_W           = 7;

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_INIT   = 24'h000002,
        S_HP     = 24'h000004,
        S_LDX    = 24'h000008,
        S_SD_L   = 24'h000010,
        S_SD_R   = 24'h000020,
        S_SD_WR  = 24'h000040,
        S_SD_CMP = 24'h000080,
        S_MG     = 24'h000100,
        S_TK0    = 24'h000200,
        S_TK1    = 24'h000400,
        S_TK2    = 24'h000800,
        S_ADD    = 24'h001000,
        S_IN_CHK = 24'h002000,
        S_IN_P   = 24'h004000,
        S_IN_CMP = 24'h008000,
        S_WR0    = 24'h010000,
        S_WR1    = 24'h020000,
        S_EX     = 24'h040000,
        S_ACT    = 24'h080000,
        S_PSH    = 24'h100000,
        S_POP    = 24'h200000,
        S_LD     = 24'h400000,
        S_DONE   = 24'h800000
    } state_t;

    typedef struct packed {
        state_t step;
        logic   take_b;
        logic   in_fire;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic hp_zero;
        logic sd_leaf;
        logic sd_stop;
        logic heap_multi;
        logic heap_zero;
        logic in_root;
        logic in_stop;
        logic node_leaf;
        logic out_free;
        logic sp_zero;
    } sts_t;

endpackage

### src/hcb_ctrl.sv
module hcb_ctrl (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_final_entry,
    input  hcb_pkg::sts_t sts,
    output hcb_pkg::cmd_t cmd,
    output logic         s_ready
);
    import hcb_pkg::*;

    typedef enum logic [1:0] {
        CTX_HEAPIFY = 2'd0,
        CTX_TAKE_A  = 2'd1,
        CTX_TAKE_B  = 2'd2
    } ctx_t;

    state_t state_reg, state_next, ret_state;
    ctx_t   ctx_reg, ctx_next;
    logic   in_fire;

    assign s_ready     = (state_reg == S_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign cmd.step    = state_reg;
    assign cmd.take_b  = (ctx_reg == CTX_TAKE_B);
    assign cmd.in_fire = in_fire;

    always_comb begin
        case (ctx_reg)
            CTX_HEAPIFY: ret_state = S_HP;
            CTX_TAKE_A:  ret_state = S_TK0;
            default:     ret_state = S_ADD;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && s_final_entry) begin
                    state_next = S_INIT;
                    ctx_next   = CTX_HEAPIFY;
                end
            end
            S_INIT:   if (sts.init_last) state_next = S_HP;
            S_HP:     state_next = sts.hp_zero ? S_MG : S_LDX;
            S_LDX:    state_next = S_SD_L;
            S_SD_L: begin
                if (sts.sd_leaf) begin
                    state_next = ret_state;
                    if (ctx_reg == CTX_TAKE_A) ctx_next = CTX_TAKE_B;
                end else begin
                    state_next = S_SD_R;
                end
            end
            S_SD_R:   state_next = S_SD_WR;
            S_SD_WR:  state_next = S_SD_CMP;
            S_SD_CMP: begin
                if (sts.sd_stop) begin
                    state_next = ret_state;
                    if (ctx_reg == CTX_TAKE_A) ctx_next = CTX_TAKE_B;
                end else begin
                    state_next = S_SD_L;
                end
            end
            S_MG: begin
                if (sts.heap_multi) begin
                    state_next = S_TK0;
                    ctx_next   = CTX_TAKE_A;
                end else begin
                    state_next = S_WR0;
                end
            end
            S_TK0:    state_next = S_TK1;
            S_TK1:    state_next = S_TK2;
            S_TK2:    state_next = S_LDX;
            S_ADD:    state_next = S_IN_CHK;
            S_IN_CHK: state_next = sts.in_root ? S_MG : S_IN_P;
            S_IN_P:   state_next = S_IN_CMP;
            S_IN_CMP: state_next = sts.in_stop ? S_MG : S_IN_CHK;
            S_WR0:    state_next = S_WR1;
            S_WR1:    state_next = S_EX;
            S_EX:     state_next = S_ACT;
            S_ACT: begin
                if (!sts.node_leaf) begin
                    state_next = S_PSH;
                end else if (sts.out_free) begin
                    state_next = sts.sp_zero ? S_DONE : S_POP;
                end
            end
            S_PSH:    state_next = S_POP;
            S_POP:    state_next = S_LD;
            S_LD:     state_next = S_EX;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctx_reg   <= CTX_HEAPIFY;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

endmodule

### src/hcb_datapath.sv
module hcb_datapath #(
    parameter int MAX_SYMBOLS   = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hcb_pkg::cmd_t                cmd,
    output hcb_pkg::sts_t                sts,
    input  logic [hcb_pkg::SYM_W-1:0]    s_symbol,
    input  logic [hcb_pkg::FREQ_W-1:0]   s_frequency,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hcb_pkg::SYM_W-1:0]    m_leaf_symbol,
    output logic [hcb_pkg::CODE_W-1:0]   m_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]    m_code_length,
    output logic                         m_final_code
);
    import hcb_pkg::*;

    localparam int PW    = $clog2(MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = $clog2(NODES);
    localparam int SW    = NW + DEPTH_W + CODE_W;

    logic [WEIGHT_W-1:0] weight_mem [NODES];
    logic [NW-1:0]       left_mem   [NODES];
    logic [NW-1:0]       right_mem  [NODES];
    logic [SYM_W-1:0]    leaf_mem   [MAX_SYMBOLS];
    logic [NW-1:0]       heap_mem   [MAX_SYMBOLS];
    logic [SW-1:0]       stack_mem  [MAX_SYMBOLS];

    logic [WEIGHT_W-1:0] weight_q;
    logic [NW-1:0]       left_q, right_q, heap_q;
    logic [SYM_W-1:0]    leaf_q;
    logic [SW-1:0]       stack_q;

    logic [CW-1:0]       cnt_reg, idx_reg, i_reg, hcnt_reg, sp_reg;
    logic [PW-1:0]       pos_reg;
    logic [NW-1:0]       x_reg, hl_reg, hr_reg, a_reg, b_reg, next_reg, node_reg;
    logic [WEIGHT_W-1:0] wx_reg, wl_reg, wa_reg, wb_reg, wsum_reg;
    logic [DEPTH_W-1:0]  len_reg;
    logic [CODE_W-1:0]   code_reg;

    logic                heap_we, weight_we, stack_we, tree_we;
    logic [PW-1:0]       heap_waddr, heap_raddr, stack_raddr;
    logic [NW-1:0]       heap_wdata, weight_waddr, weight_raddr;
    logic [WEIGHT_W-1:0] weight_wdata, wsum;
    logic [SW-1:0]       stack_wdata;

    logic [PW+1:0]       l_idx, r_idx;
    logic [PW-1:0]       parent;
    logic                full, r_ok, lt_l, lt_r, in_lt, emit;
    logic [WEIGHT_W-1:0] best_w;
    logic [DEPTH_W-1:0]  len_inc;
    logic [CODE_W-1:0]   code_sh;

    assign full    = (cnt_reg == CW'(MAX_SYMBOLS));
    assign l_idx   = (PW+2)'({pos_reg, 1'b1});
    assign r_idx   = l_idx + 1'b1;
    assign parent  = (pos_reg - 1'b1) >> 1;
    assign r_ok    = r_idx < (PW+2)'(hcnt_reg);
    assign lt_l    = wl_reg < wx_reg;
    assign best_w  = lt_l ? wl_reg : wx_reg;
    assign lt_r    = r_ok && (weight_q < best_w);
    assign in_lt   = wsum_reg < weight_q;
    assign wsum    = wa_reg + wb_reg;
    assign len_inc = len_reg + 1'b1;
    assign code_sh = (len_reg < DEPTH_W'(MAX_CODE_BITS)) ? {code_reg[CODE_W-2:0], 1'b0}
                                                        : code_reg;
    assign emit    = (cmd.step == S_ACT) && sts.node_leaf && sts.out_free;

    assign sts.init_last  = (idx_reg == cnt_reg - 1'b1);
    assign sts.hp_zero    = (i_reg == '0);
    assign sts.sd_leaf    = l_idx >= (PW+2)'(hcnt_reg);
    assign sts.sd_stop    = !lt_l && !lt_r;
    assign sts.heap_multi = hcnt_reg > CW'(1);
    assign sts.heap_zero  = (hcnt_reg == '0);
    assign sts.in_root    = (pos_reg == '0);
    assign sts.in_stop    = !in_lt;
    assign sts.node_leaf  = node_reg < NW'(cnt_reg);
    assign sts.out_free   = !m_valid || m_ready;
    assign sts.sp_zero    = (sp_reg == '0);

    always_comb begin
        heap_we      = 1'b0;
        heap_waddr   = pos_reg;
        heap_wdata   = x_reg;
        heap_raddr   = '0;
        weight_we    = 1'b0;
        weight_waddr = next_reg;
        weight_wdata = wsum;
        weight_raddr = heap_q;
        tree_we      = 1'b0;
        stack_we     = 1'b0;
        stack_wdata  = {left_q, len_inc, code_sh};
        stack_raddr  = PW'(sp_reg - 1'b1);
        case (cmd.step)
            S_IDLE: begin
                weight_we    = cmd.in_fire && !full;
                weight_waddr = NW'(cnt_reg);
                weight_wdata = WEIGHT_W'(s_frequency);
            end
            S_INIT: begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg[PW-1:0];
                heap_wdata = NW'(idx_reg);
            end
            S_HP:     weight_raddr = NW'(i_reg - 1'b1);
            S_SD_L: begin
                heap_we    = sts.sd_leaf;
                heap_raddr = l_idx[PW-1:0];
            end
            S_SD_R:   heap_raddr = r_idx[PW-1:0];
            S_SD_CMP: begin
                heap_we    = 1'b1;
                heap_wdata = lt_r ? hr_reg : (lt_l ? hl_reg : x_reg);
            end
            S_TK1:    heap_raddr = PW'(hcnt_reg - 1'b1);
            S_ADD: begin
                weight_we = 1'b1;
                tree_we   = 1'b1;
            end
            S_IN_CHK: begin
                heap_we    = sts.in_root;
                heap_wdata = next_reg;
                heap_raddr = parent;
            end
            S_IN_CMP: begin
                heap_we    = 1'b1;
                heap_wdata = in_lt ? hl_reg : next_reg;
            end
            S_ACT: begin
                stack_we    = !sts.node_leaf;
                stack_wdata = {right_q, len_inc,
                               code_sh | CODE_W'(len_reg < DEPTH_W'(MAX_CODE_BITS))};
            end
            S_PSH:    stack_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
        heap_q <= heap_mem[heap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (weight_we) weight_mem[weight_waddr] <= weight_wdata;
        weight_q <= weight_mem[weight_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tree_we) begin
            left_mem[next_reg]  <= a_reg;
            right_mem[next_reg] <= b_reg;
        end
        left_q  <= left_mem[node_reg];
        right_q <= right_mem[node_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.step == S_IDLE && cmd.in_fire && !full) leaf_mem[cnt_reg[PW-1:0]] <= s_symbol;
        leaf_q <= leaf_mem[node_reg[PW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) stack_mem[sp_reg[PW-1:0]] <= stack_wdata;
        stack_q <= stack_mem[stack_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            hcnt_reg <= '0;
            m_valid  <= 1'b0;
        end else begin
            if (emit) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (cmd.step)
                S_IDLE:   if (cmd.in_fire && !full) cnt_reg <= cnt_reg + 1'b1;
                S_INIT:   hcnt_reg <= cnt_reg;
                S_TK2:    hcnt_reg <= hcnt_reg - 1'b1;
                S_ADD:    hcnt_reg <= hcnt_reg + 1'b1;
                S_DONE: begin
                    cnt_reg  <= '0;
                    hcnt_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_leaf_symbol <= leaf_q;
            m_code_bits   <= code_reg;
            m_code_length <= (len_reg < DEPTH_W'(MAX_CODE_BITS)) ? len_reg[LEN_W-1:0]
                                                                : LEN_W'(MAX_CODE_BITS);
            m_final_code  <= sts.sp_zero;
        end
        case (cmd.step)
            S_IDLE:   idx_reg <= '0;
            S_INIT: begin
                idx_reg  <= idx_reg + 1'b1;
                i_reg    <= cnt_reg >> 1;
                next_reg <= NW'(cnt_reg);
            end
            S_HP: begin
                if (!sts.hp_zero) begin
                    i_reg   <= i_reg - 1'b1;
                    pos_reg <= PW'(i_reg - 1'b1);
                    x_reg   <= NW'(i_reg - 1'b1);
                end
            end
            S_LDX:    wx_reg <= weight_q;
            S_SD_R:   hl_reg <= heap_q;
            S_SD_WR: begin
                hr_reg <= heap_q;
                wl_reg <= weight_q;
            end
            S_SD_CMP: begin
                if (lt_r) pos_reg <= r_idx[PW-1:0];
                else if (lt_l) pos_reg <= l_idx[PW-1:0];
            end
            S_TK1: begin
                if (cmd.take_b) b_reg <= heap_q;
                else a_reg <= heap_q;
            end
            S_TK2: begin
                if (cmd.take_b) wb_reg <= weight_q;
                else wa_reg <= weight_q;
                x_reg   <= heap_q;
                pos_reg <= '0;
            end
            S_ADD: begin
                wsum_reg <= wsum;
                pos_reg  <= PW'(hcnt_reg);
            end
            S_IN_CHK: if (sts.in_root) next_reg <= next_reg + 1'b1;
            S_IN_P:   hl_reg <= heap_q;
            S_IN_CMP: begin
                if (in_lt) pos_reg <= parent;
                else next_reg <= next_reg + 1'b1;
            end
            S_WR1: begin
                node_reg <= heap_q;
                len_reg  <= '0;
                code_reg <= '0;
                sp_reg   <= '0;
            end
            S_ACT:    if (!sts.node_leaf) sp_reg <= sp_reg + 1'b1;
            S_PSH:    sp_reg <= sp_reg + 1'b1;
            S_POP:    sp_reg <= sp_reg - 1'b1;
            S_LD: begin
                node_reg <= stack_q[SW-1 -: NW];
                len_reg  <= stack_q[CODE_W +: DEPTH_W];
                code_reg <= stack_q[CODE_W-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

### src/huffman_code_builder.sv
// Huffman code builder.
// The input channel (s_) takes one symbol and its frequency per request, one
// request per cycle while the block is loading. The request with s_final_entry
// set closes the set and starts the build; requests beyond MAX_SYMBOLS are
// dropped, but a dropped final request still starts the build.
// During the build s_ready is low. The build first loads the heap, then runs
// heap sifts through heap and weight memories with one read and one write
// port each: each sift-down level runs S_SD_L, S_SD_R, S_SD_WR, S_SD_CMP,
// each sift-up level S_IN_CHK, S_IN_P, S_IN_CMP, over n - 1 merges in all.
// The result channel (m_) then gives one request per leaf, in left-to-right
// order, with the code, its length and a final flag on the last one. The tree
// walk takes each node through S_EX and S_ACT, an internal node also through
// S_PSH, then pops the next node in S_POP and S_LD until the stack is empty.
// The result register frees the walk from the receiver; a stall on m_ready
// holds the walk at the next leaf. New loads are taken once the walk is done.
// Reset clears the loaded count and m_valid; a set in progress is lost.
`include "huffman_code_builder_defines.svh"

module huffman_code_builder #(
    parameter int MAX_SYMBOLS   = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hcb_pkg::SYM_W-1:0]   s_symbol,
    input  logic [hcb_pkg::FREQ_W-1:0]  s_frequency,
    input  logic                        s_final_entry,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hcb_pkg::SYM_W-1:0]   m_leaf_symbol,
    output logic [hcb_pkg::CODE_W-1:0]  m_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]   m_code_length,
    output logic                        m_final_code
);
    import hcb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hcb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_final_entry (s_final_entry),
        .sts           (sts),
        .cmd           (cmd),
        .s_ready       (s_ready)
    );

    hcb_datapath #(
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_symbol      (s_symbol),
        .s_frequency   (s_frequency),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_leaf_symbol (m_leaf_symbol),
        .m_code_bits   (m_code_bits),
        .m_code_length (m_code_length),
        .m_final_code  (m_final_code)
    );

    `HCB_CHECK_IMP(idle_heap_empty, s_ready, sts.heap_zero)
    `HCB_CHECK_IMP(pop_nonempty, cmd.step == S_POP, !sts.sp_zero)
    `HCB_CHECK(no_load_while_walking, !(cmd.step == S_ACT && s_ready))

endmodule
